// ----- sv/ycrgb_pkg.sv -----
package ycrgb_pkg;

    // Field widths of the stream words.
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned TERM_W   = 64;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned IN_FIELDS = 10;
    localparam int unsigned IN_DATA_W = IN_FIELDS * SUM_W;
    localparam int unsigned OUT_DATA_W = 3 * BYTE_W;
    localparam int unsigned CFG_IDX_W = 3;

    // Bit offsets of the sums inside s_tdata, lowest field first.
    localparam int unsigned LUMA_RED_LSB   = 0 * SUM_W;
    localparam int unsigned LUMA_GREEN_LSB = 1 * SUM_W;
    localparam int unsigned LUMA_BLUE_LSB  = 2 * SUM_W;
    localparam int unsigned CR_FIRST_LSB   = 3 * SUM_W;
    localparam int unsigned CR_SECOND_LSB  = 4 * SUM_W;
    localparam int unsigned CR_THIRD_LSB   = 5 * SUM_W;
    localparam int unsigned CB_FIRST_LSB   = 6 * SUM_W;
    localparam int unsigned CB_SECOND_LSB  = 7 * SUM_W;
    localparam int unsigned CB_THIRD_LSB   = 8 * SUM_W;
    localparam int unsigned CB_LEAD_LSB    = 9 * SUM_W;

    // Channel offsets in Q32: integer part in the high word.
    localparam logic [TERM_W-1:0] BLUE_OFFSET  = {32'd220, 32'd687194767};
    localparam logic [TERM_W-1:0] GREEN_OFFSET = {32'd135, 32'd1974997761};
    localparam logic [TERM_W-1:0] RED_OFFSET   = {32'd179, 32'd1958505087};
    localparam logic [SUM_W-1:0]  CHAN_MAX     = 32'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LUMA_SCALE    = 3'd0,
        REG_CB_BLUE_GAIN  = 3'd1,
        REG_CB_GREEN_GAIN = 3'd2,
        REG_CR_GREEN_GAIN = 3'd3,
        REG_CR_RED_GAIN   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [SUM_W-1:0] luma_scale;
        logic [SUM_W-1:0] cb_blue_gain;
        logic [SUM_W-1:0] cb_green_gain;
        logic [SUM_W-1:0] cr_green_gain;
        logic [SUM_W-1:0] cr_red_gain;
    } cfg_t;

    // Round the signed high word up when low-word bit 31 is set, then clamp.
    // A high word that wraps negative on rounding clamps to zero.
    function automatic logic [BYTE_W-1:0] round_clamp(input logic [TERM_W-1:0] t);
        logic [SUM_W-1:0] h;
        h = t[TERM_W-1:SUM_W] + {{(SUM_W-1){1'b0}}, t[SUM_W-1]};
        if (h <= CHAN_MAX) begin
            return h[BYTE_W-1:0];
        end else if (h[SUM_W-1]) begin
            return {BYTE_W{1'b0}};
        end else begin
            return CHAN_MAX[BYTE_W-1:0];
        end
    endfunction

endpackage

// ----- sv/ycbcr_to_rgb_subpixel_line.sv -----
// Three stages: window sums, the seven parallel 32x32 products, and the final
// 64-bit sum with round and clamp; a word passes through all three registers.
// Throughput: one word per clock while m_tready does not stall the output.
// Reset (aresetn low, synchronous): all stage valid bits, the carried Cr and
// Cb samples and the five configuration registers clear to zero.
// Ready ripples back from m_tready, so an empty stage always takes a new word.
module ycbcr_to_rgb_subpixel_line
    import ycrgb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SUM_W-1:0]      cfg_wdata,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, lowest bits first: luma_red, luma_green, luma_blue, cr_first,
    // cr_second, cr_third, cb_first, cb_second, cb_third, cb_lead.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,   // line_end
    input  logic                  s_tuser,   // line_start
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, lowest bits first: blue_byte, green_byte, red_byte.
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cfg_t cfg;

    ycrgb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Unpack the input word.
    logic [SUM_W-1:0] in_luma_red, in_luma_green, in_luma_blue;
    logic [SUM_W-1:0] in_cr_first, in_cr_second, in_cr_third;
    logic [SUM_W-1:0] in_cb_first, in_cb_second, in_cb_third, in_cb_lead;

    assign in_luma_red   = s_tdata[LUMA_RED_LSB   +: SUM_W];
    assign in_luma_green = s_tdata[LUMA_GREEN_LSB +: SUM_W];
    assign in_luma_blue  = s_tdata[LUMA_BLUE_LSB  +: SUM_W];
    assign in_cr_first   = s_tdata[CR_FIRST_LSB   +: SUM_W];
    assign in_cr_second  = s_tdata[CR_SECOND_LSB  +: SUM_W];
    assign in_cr_third   = s_tdata[CR_THIRD_LSB   +: SUM_W];
    assign in_cb_first   = s_tdata[CB_FIRST_LSB   +: SUM_W];
    assign in_cb_second  = s_tdata[CB_SECOND_LSB  +: SUM_W];
    assign in_cb_third   = s_tdata[CB_THIRD_LSB   +: SUM_W];
    assign in_cb_lead    = s_tdata[CB_LEAD_LSB    +: SUM_W];

    // Handshake chain. Each stage moves forward when it is empty or when the
    // stage after it moves, so a stall at the output holds every full stage.
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic out_ready, s2_ready, s1_ready, in_fire;

    assign out_ready = !m_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign in_fire   = s_tvalid && s1_ready;

    // Chroma window. At line start the previous samples come from the word
    // itself (cr_first, cb_lead); at line end cb_third is replaced by
    // cb_second. The carried samples are updated on every accepted word.
    logic [SUM_W-1:0] carried_cr_reg, carried_cr_next;
    logic [SUM_W-1:0] carried_cb_reg, carried_cb_next;
    logic [SUM_W-1:0] prev_cr, prev_cb, cb_next_sample;

    assign prev_cr        = s_tuser ? in_cr_first : carried_cr_reg;
    assign prev_cb        = s_tuser ? in_cb_lead  : carried_cb_reg;
    assign cb_next_sample = s_tlast ? in_cb_second : in_cb_third;

    assign carried_cr_next = in_fire ? in_cr_third    : carried_cr_reg;
    assign carried_cb_next = in_fire ? cb_next_sample : carried_cb_reg;

    // Stage 1: 32-bit wrapping window sums and the luma sums.
    logic [SUM_W-1:0] cb_win_b_reg, cb_win_g_reg, cr_win_g_reg, cr_win_r_reg;
    logic [SUM_W-1:0] y_r_reg, y_g_reg, y_b_reg;
    logic [SUM_W-1:0] cb_win_b_next, cb_win_g_next, cr_win_g_next, cr_win_r_next;

    assign cb_win_b_next = in_cb_first + in_cb_second + cb_next_sample;
    assign cb_win_g_next = prev_cb + in_cb_first + in_cb_second;
    assign cr_win_g_next = in_cr_first + in_cr_second + in_cr_third;
    assign cr_win_r_next = prev_cr + in_cr_first + in_cr_second;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            carried_cr_reg <= '0;
            carried_cb_reg <= '0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_tvalid;
            end
            carried_cr_reg <= carried_cr_next;
            carried_cb_reg <= carried_cb_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cb_win_b_reg <= cb_win_b_next;
            cb_win_g_reg <= cb_win_g_next;
            cr_win_g_reg <= cr_win_g_next;
            cr_win_r_reg <= cr_win_r_next;
            y_r_reg      <= in_luma_red;
            y_g_reg      <= in_luma_green;
            y_b_reg      <= in_luma_blue;
        end
    end

    // Stage 2: seven independent 32x32 products. A zero luma scale stands
    // for a scale of one in Q32, so the luma sum is just moved to the high word.
    logic [TERM_W-1:0] luma_r_reg, luma_g_reg, luma_b_reg;
    logic [TERM_W-1:0] cb_blue_reg, cb_green_reg, cr_green_reg, cr_red_reg;
    logic [TERM_W-1:0] luma_r_next, luma_g_next, luma_b_next;
    logic              luma_identity;
    logic              s2_load;

    assign luma_identity = (cfg.luma_scale == '0);
    assign s2_load       = s1_valid_reg && s2_ready;

    assign luma_r_next = luma_identity ? {y_r_reg, {SUM_W{1'b0}}}
                                       : TERM_W'(cfg.luma_scale) * TERM_W'(y_r_reg);
    assign luma_g_next = luma_identity ? {y_g_reg, {SUM_W{1'b0}}}
                                       : TERM_W'(cfg.luma_scale) * TERM_W'(y_g_reg);
    assign luma_b_next = luma_identity ? {y_b_reg, {SUM_W{1'b0}}}
                                       : TERM_W'(cfg.luma_scale) * TERM_W'(y_b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            luma_r_reg   <= luma_r_next;
            luma_g_reg   <= luma_g_next;
            luma_b_reg   <= luma_b_next;
            cb_blue_reg  <= TERM_W'(cfg.cb_blue_gain)  * TERM_W'(cb_win_b_reg);
            cb_green_reg <= TERM_W'(cfg.cb_green_gain) * TERM_W'(cb_win_g_reg);
            cr_green_reg <= TERM_W'(cfg.cr_green_gain) * TERM_W'(cr_win_g_reg);
            cr_red_reg   <= TERM_W'(cfg.cr_red_gain)   * TERM_W'(cr_win_r_reg);
        end
    end

    // Stage 3: modulo 2^64 channel sums, then round and clamp to a byte.
    logic [TERM_W-1:0]     term_b, term_g, term_r;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                  out_load;

    assign term_b = luma_b_reg + {cb_blue_reg[TERM_W-2:0], 1'b0} - BLUE_OFFSET;
    assign term_g = luma_g_reg + GREEN_OFFSET - cb_green_reg - cr_green_reg;
    assign term_r = luma_r_reg + {cr_red_reg[TERM_W-2:0], 1'b0} - RED_OFFSET;

    assign m_data_next = {round_clamp(term_r), round_clamp(term_g), round_clamp(term_b)};
    assign out_load    = s2_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // An empty first stage never holds off the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with an empty first stage");

    // The carried Cr sample is the last accepted word's cr_third.
    a_carried_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> carried_cr_reg == $past(in_cr_third))
        else $error("carried Cr sample not taken from the accepted word");

    // At line end the carried Cb sample is cb_second, not cb_third.
    a_carried_cb_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tlast) |=> carried_cb_reg == $past(in_cb_second))
        else $error("carried Cb sample wrong at line end");

    // A result waiting on the output is not overwritten by the stage behind it.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> m_valid_reg && $stable(m_data_reg))
        else $error("stalled result changed");

    // An empty pipe cannot raise m_tvalid before a word has passed stages 1 and 2.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s1_valid_reg && !s2_valid_reg && !m_valid_reg) |=> !m_valid_reg)
        else $error("result appeared without passing through the pipeline");

endmodule

// ----- sv/ycrgb_cfg.sv -----
module ycrgb_cfg
    import ycrgb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SUM_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Indexes past the last register are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_LUMA_SCALE:    cfg_next.luma_scale    = cfg_wdata;
                REG_CB_BLUE_GAIN:  cfg_next.cb_blue_gain  = cfg_wdata;
                REG_CB_GREEN_GAIN: cfg_next.cb_green_gain = cfg_wdata;
                REG_CR_GREEN_GAIN: cfg_next.cr_green_gain = cfg_wdata;
                REG_CR_RED_GAIN:   cfg_next.cr_red_gain   = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
